// ===== rtl/modbus_read_response_checker_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef MODBUS_READ_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_READ_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle property, sampled on clk, off while in reset.
`define MBRRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define MBRRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mbrrc_pkg.sv =====
package mbrrc_pkg;

  // Input item: one reply byte or a timeout mark.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } mbrrc_in_t;

  // Result item: provisional data word or closing frame status.
  typedef struct packed {
    logic        kind;
    logic [15:0] word_value;
    logic [6:0]  word_index;
    logic [2:0]  status;
    logic [7:0]  exception_code;
  } mbrrc_out_t;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Frame status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TIMEOUT    = 3'd1;
  localparam logic [2:0] ST_CRC_BAD    = 3'd2;
  localparam logic [2:0] ST_WRONG_ADDR = 3'd3;
  localparam logic [2:0] ST_EXCEPTION  = 3'd4;
  localparam logic [2:0] ST_BAD_FUNC   = 3'd5;
  localparam logic [2:0] ST_COUNT_BAD  = 3'd6;

  // Config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_COUNT  = 1'b1;

  // Protocol constants
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0]  FUNC_EXC_FLAG  = 8'h80;

  localparam logic [7:0] SLAVE_ADDR_RST = 8'd9;
  localparam logic [6:0] EXP_COUNT_RST  = 7'd1;

  // CRC-16, reflected, one byte folded in (eight unrolled shift steps).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/modbus_read_response_checker.sv =====
// Latency: an accepted item's result (if any) shows on out_* the next cycle when
//   the output register is free; a stalled output parks it in a skid register.
// Throughput: one item per cycle; CRC, header checks and word assembly are one
//   registered pass. in_stall rises only while the skid register is occupied.
// Reset (rst_n low, synchronous): frame idle, CRC at FFFF, slave_address 9,
//   expected_count 1, both result registers empty.
module modbus_read_response_checker import mbrrc_pkg::*; #(
  parameter int MAX_REGISTERS = 125
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // reply bytes
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mbrrc_in_t            in_item,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output mbrrc_out_t           out_item,
  // config writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam logic [6:0] MAX_REG_W = 7'(MAX_REGISTERS);

  // Config registers
  logic [7:0] slave_addr_r;
  logic [6:0] exp_count_r;

  // Frame state
  logic [7:0]  pos_r,      pos_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [7:0]  addr_r,     addr_nxt;
  logic [7:0]  func_r,     func_nxt;
  logic [7:0]  cnt_r,      cnt_nxt;
  logic [7:0]  hi_r,       hi_nxt;

  // Frame state with the current byte folded in, before any frame close
  logic [15:0] crc_upd;
  logic [7:0]  addr_upd;
  logic [7:0]  func_upd;
  logic [7:0]  cnt_upd;

  // Output register plus skid register
  logic       out_valid_r, skid_valid_r;
  mbrrc_out_t out_r, skid_r;

  logic       accept;
  logic       take_out;
  logic       res_v;
  mbrrc_out_t res;

  logic [6:0] n_regs;
  logic [8:0] last_pos;     // 5 + 2N - 1, up to 254
  logic       frame_end;
  logic       in_words;
  logic [6:0] word_idx;
  logic [2:0] fin_status;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign accept   = in_valid && !skid_valid_r;
  assign take_out = out_valid_r && !out_stall;

  // Clamp requested count; frame length follows from it.
  assign n_regs   = (exp_count_r > MAX_REG_W) ? MAX_REG_W : exp_count_r;
  assign last_pos = 9'd4 + {1'b0, n_regs, 1'b0};

  assign frame_end = ({1'b0, pos_r} >= last_pos);
  // Data region: positions 3 .. last-2; odd positions carry the high byte.
  assign in_words  = (pos_r >= 8'd3) && (({1'b0, pos_r} + 9'd2) <= last_pos);
  // low byte sits at an even position: index = pos/2 - 2
  assign word_idx  = pos_r[7:1] - 7'd2;

  assign crc_upd  = crc16_byte(crc_r, in_item.rx_byte);
  assign addr_upd = (pos_r == 8'd0) ? in_item.rx_byte : addr_r;
  assign func_upd = (pos_r == 8'd1) ? in_item.rx_byte : func_r;
  assign cnt_upd  = (pos_r == 8'd2) ? in_item.rx_byte : cnt_r;

  // Status priority: crc, address, exception, function, byte count.
  always_comb begin
    if (crc_upd != 16'h0000) begin
      fin_status = ST_CRC_BAD;
    end else if (addr_upd != slave_addr_r) begin
      fin_status = ST_WRONG_ADDR;
    end else if (func_upd == (FUNC_READ_HOLD | FUNC_EXC_FLAG)) begin
      fin_status = ST_EXCEPTION;
    end else if (func_upd != FUNC_READ_HOLD) begin
      fin_status = ST_BAD_FUNC;
    end else if (cnt_upd != {n_regs, 1'b0}) begin
      fin_status = ST_COUNT_BAD;
    end else begin
      fin_status = ST_OK;
    end
  end

  // One pass over the accepted item: next frame state and the result it causes.
  always_comb begin
    crc_nxt  = crc_upd;
    addr_nxt = addr_upd;
    func_nxt = func_upd;
    cnt_nxt  = cnt_upd;
    pos_nxt  = pos_r + 8'd1;
    hi_nxt   = hi_r;

    res_v              = 1'b0;
    res.kind           = KIND_DATA;
    res.word_value     = 16'h0000;
    res.word_index     = 7'd0;
    res.status         = ST_OK;
    res.exception_code = 8'h00;

    if (in_item.timed_out) begin
      // abandon the frame
      pos_nxt    = 8'd0;
      crc_nxt    = CRC_INIT;
      addr_nxt   = 8'h00;
      func_nxt   = 8'h00;
      cnt_nxt    = 8'h00;
      hi_nxt     = 8'h00;
      res_v      = 1'b1;
      res.kind   = KIND_STATUS;
      res.status = ST_TIMEOUT;
    end else if (frame_end) begin
      res_v      = 1'b1;
      res.kind   = KIND_STATUS;
      res.status = fin_status;
      if (fin_status == ST_EXCEPTION) begin
        res.exception_code = cnt_upd;
      end
      pos_nxt  = 8'd0;
      crc_nxt  = CRC_INIT;
      addr_nxt = 8'h00;
      func_nxt = 8'h00;
      cnt_nxt  = 8'h00;
      hi_nxt   = 8'h00;
    end else if (in_words) begin
      if (pos_r[0]) begin
        hi_nxt = in_item.rx_byte;
      end else begin
        res_v          = 1'b1;
        res.word_value = {hi_r, in_item.rx_byte};
        res.word_index = word_idx;
      end
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= SLAVE_ADDR_RST;
      exp_count_r  <= EXP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_data;
        CFG_EXP_COUNT:  exp_count_r  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 8'd0;
      crc_r  <= CRC_INIT;
      addr_r <= 8'h00;
      func_r <= 8'h00;
      cnt_r  <= 8'h00;
      hi_r   <= 8'h00;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      addr_r <= addr_nxt;
      func_r <= func_nxt;
      cnt_r  <= cnt_nxt;
      hi_r   <= hi_nxt;
    end
  end

  // Result handoff: skid drains first; new result goes to the output register
  // when it frees up, else into the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take_out) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || take_out) begin
      out_valid_r <= accept && res_v;
    end else if (accept && res_v) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take_out) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || take_out) begin
      out_r <= res;
    end else begin
      skid_r <= res;
    end
  end

endmodule

// ===== rtl/mbrrc_checker.sv =====
`include "modbus_read_response_checker_macros.svh"

module mbrrc_checker import mbrrc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input mbrrc_in_t  in_item,
  input logic       out_valid,
  input logic       out_stall,
  input mbrrc_out_t out_item
);

  `MBRRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")
  `MBRRC_ASSERT(a_status_clean, !(out_valid && out_item.kind == KIND_STATUS) || (out_item.word_value == 16'h0000 && out_item.word_index == 7'd0), "status item carries word fields")
  `MBRRC_ASSERT(a_data_clean, !(out_valid && out_item.kind == KIND_DATA) || (out_item.status == ST_OK && out_item.exception_code == 8'h00), "data item carries status fields")
  `MBRRC_ASSERT(a_exc_only, !(out_valid && out_item.status != ST_EXCEPTION) || (out_item.exception_code == 8'h00), "exception code without exception status")
  `MBRRC_ASSERT_NEXT(a_timeout_lat, in_valid && !in_stall && in_item.timed_out && !out_valid, out_valid && out_item.kind == KIND_STATUS && out_item.status == ST_TIMEOUT, "timeout item gave no timeout status")

endmodule

bind modbus_read_response_checker mbrrc_checker u_mbrrc_checker (.*);

// ===== dv/modbus_read_response_checker_tb.sv =====
module modbus_read_response_checker_tb;
  import mbrrc_pkg::*;

  localparam int MAX_REGS      = 125;
  localparam int ITEM_TARGET   = 1500;    // reply bytes plus timeout marks
  localparam int PHASE_ITEMS   = 60;      // items per config setting, at least
  localparam int SETTLE_CYCLES = 4;       // result register plus skid, with margin
  localparam int LIMIT         = 600000;  // watchdog, cycles

  // Directed script: one row is one item, a pair of CRC bytes, or a register write.
  typedef enum logic [1:0] {ROW_BYTE, ROW_TIMEOUT, ROW_CRC, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e              op;
    logic [7:0]           val;      // byte, CRC low-byte xor mask, or register data
    logic [CFG_IDX_W-1:0] reg_sel;
    bit                   typed;    // want holds a hand-written expectation
    mbrrc_out_t           want;
  } script_row_t;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  mbrrc_in_t            in_item   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mbrrc_out_t           out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SLAVE_ADDR;
  logic [7:0]           cfg_data  = 8'h00;

  modbus_read_response_checker #(.MAX_REGISTERS(MAX_REGS)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Our own copy of the checker: register settings and the frame in progress.
  logic [7:0]  cfg_slave = SLAVE_ADDR_RST;
  logic [6:0]  cfg_count = EXP_COUNT_RST;
  int          frame_pos = 0;
  logic [15:0] frame_crc = CRC_INIT;
  logic [7:0]  hdr_addr  = 8'h00;
  logic [7:0]  hdr_func  = 8'h00;
  logic [7:0]  hdr_count = 8'h00;
  logic [7:0]  word_hi   = 8'h00;

  mbrrc_out_t  awaited_reply_results[$];
  script_row_t script[$];

  bit calm = 1'b0;            // no sender gaps, no receiver stalls
  int stall_left = 0;
  int items_sent = 0;
  int results_seen = 0;
  int words_seen = 0;
  int settings_used = 0;
  int status_seen[8];
  int mismatch_count = 0;
  int cycle_count = 0;

  // Reflected CRC-16, fed one bit at a time, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    acc = c;
    for (int k = 0; k < 8; k++) begin
      acc = (acc >> 1) ^ ((acc[0] ^ b[k]) ? CRC_POLY : 16'h0000);
    end
    return acc;
  endfunction

  // Counts above the parameter are clamped by the block.
  function automatic int regs_requested();
    return (cfg_count > MAX_REGS) ? MAX_REGS : int'(cfg_count);
  endfunction

  function automatic void restart_frame();
    frame_pos = 0;
    frame_crc = CRC_INIT;
    hdr_addr  = 8'h00;
    hdr_func  = 8'h00;
    hdr_count = 8'h00;
    word_hi   = 8'h00;
  endfunction

  // Advance the frame by one accepted item; returns 1 with res filled when the
  // item produces a data word or closes the frame.
  function automatic bit check_reply_byte(input mbrrc_in_t it, output mbrrc_out_t res);
    int         n;
    int         last;
    int         pos;
    logic [7:0] b;
    n    = regs_requested();
    last = 4 + 2 * n;
    pos  = frame_pos;
    b    = it.rx_byte;
    res  = '0;
    // a timeout closes the frame even when nothing has arrived yet
    if (it.timed_out) begin
      restart_frame();
      res.kind   = KIND_STATUS;
      res.status = ST_TIMEOUT;
      return 1'b1;
    end
    frame_crc = crc_fold(frame_crc, b);
    case (pos)
      0: hdr_addr  = b;
      1: hdr_func  = b;
      2: hdr_count = b;
      default: ;
    endcase
    // end of frame; a mid-frame count change can put pos past the end
    if (pos >= last) begin
      res.kind = KIND_STATUS;
      if (frame_crc != 16'h0000)                          res.status = ST_CRC_BAD;
      else if (hdr_addr != cfg_slave)                     res.status = ST_WRONG_ADDR;
      else if (hdr_func == (FUNC_READ_HOLD | FUNC_EXC_FLAG)) begin
        res.status         = ST_EXCEPTION;
        res.exception_code = hdr_count;
      end
      else if (hdr_func != FUNC_READ_HOLD)                res.status = ST_BAD_FUNC;
      else if (int'(hdr_count) != 2 * n)                  res.status = ST_COUNT_BAD;
      else                                                res.status = ST_OK;
      restart_frame();
      return 1'b1;
    end
    frame_pos = pos + 1;
    // data area: odd positions hold the high byte, even ones complete a word
    if (pos >= 3 && pos + 2 <= last) begin
      if (pos % 2 == 1) begin
        word_hi = b;
      end else begin
        res.kind       = KIND_DATA;
        res.word_value = {word_hi, b};
        res.word_index = 7'((pos - 4) / 2);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic mbrrc_in_t byte_item(input logic [7:0] b);
    return '{rx_byte: b, timed_out: 1'b0};
  endfunction

  // rx_byte rides along on a timeout mark and must be ignored
  function automatic mbrrc_in_t timeout_item(input logic [7:0] b);
    return '{rx_byte: b, timed_out: 1'b1};
  endfunction

  function automatic mbrrc_out_t word_res(input logic [15:0] v, input logic [6:0] idx);
    mbrrc_out_t r;
    r            = '0;
    r.kind       = KIND_DATA;
    r.word_value = v;
    r.word_index = idx;
    return r;
  endfunction

  function automatic mbrrc_out_t stat_res(input logic [2:0] st, input logic [7:0] exc);
    mbrrc_out_t r;
    r                = '0;
    r.kind           = KIND_STATUS;
    r.status         = st;
    r.exception_code = exc;
    return r;
  endfunction

  function automatic void add_row(input row_op_e op, input logic [7:0] val,
                                  input bit typed = 1'b0, input mbrrc_out_t want = '0);
    script.insert(script.size(),
                  '{op: op, val: val, reg_sel: CFG_SLAVE_ADDR, typed: typed, want: want});
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    script.insert(script.size(),
                  '{op: ROW_CFG, val: val, reg_sel: idx, typed: 1'b0, want: '0});
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // Sender gap: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one item at the falling edge, hold it until taken, then predict.
  // A hand-written expectation, when given, is queued instead of the prediction.
  task automatic send_item(input mbrrc_in_t it, input bit typed = 1'b0,
                           input mbrrc_out_t want = '0);
    int         gap;
    bit         has;
    mbrrc_out_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    has = check_reply_byte(it, res);
    if (typed) awaited_reply_results.insert(awaited_reply_results.size(), want);
    else if (has) awaited_reply_results.insert(awaited_reply_results.size(), res);
  endtask

  // Sender holds off until every awaited result is out, then waits SETTLE_CYCLES
  // more for anything still in flight from items that gave no result.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_reply_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLAVE_ADDR) cfg_slave = val;
    else cfg_count = val[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One reply: mostly well-formed with random words, some with bad headers, a
  // bad CRC, cut short by a timeout, or plain line noise.
  task automatic send_random_frame();
    logic [7:0]  frame[$];
    logic [15:0] crc;
    int          n;
    int          len;
    int          r;
    int          k;
    int          cut;
    n   = regs_requested();
    len = 5 + 2 * n;
    r   = $urandom_range(0, 99);
    if (r < 8) begin
      cut = $urandom_range(1, len - 1);
      repeat (cut) send_item(byte_item(8'($urandom_range(0, 255))));
      send_item(timeout_item(8'($urandom_range(0, 255))));
      return;
    end
    frame.insert(frame.size(), ($urandom_range(0, 9) == 0) ?
                 cfg_slave ^ 8'($urandom_range(1, 255)) : cfg_slave);
    k = $urandom_range(0, 99);
    frame.insert(frame.size(), (k < 80) ? FUNC_READ_HOLD :
                 (k < 90) ? (FUNC_READ_HOLD | FUNC_EXC_FLAG) : 8'($urandom_range(0, 255)));
    frame.insert(frame.size(),
                 ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'(2 * n));
    repeat (2 * n) begin
      k = $urandom_range(0, 99);
      frame.insert(frame.size(),
                   (k < 10) ? 8'h00 : (k < 20) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
    crc = CRC_INIT;
    foreach (frame[i]) crc = crc_fold(crc, frame[i]);
    frame.insert(frame.size(), crc[7:0]);
    frame.insert(frame.size(), crc[15:8]);
    // corrupt one byte anywhere, header and CRC included
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, len - 1);
      frame[k] ^= 8'($urandom_range(1, 255));
    end
    cut = (r < 16) ? $urandom_range(1, len - 1) : len;
    for (int i = 0; i < cut; i++) send_item(byte_item(frame[i]));
    if (cut < len) send_item(timeout_item(8'($urandom_range(0, 255))));
  endtask

  // One setting of the registers and a batch of replies under it.
  task automatic run_phase(input bit write_all);
    int         r;
    int         start;
    logic [7:0] val;
    // every phase starts from an empty pipeline (the sender waits it out)
    settle();
    if (write_all || $urandom_range(0, 3) != 0) begin
      r   = $urandom_range(0, 99);
      val = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 255));
      write_reg(CFG_SLAVE_ADDR, val);
    end
    if (write_all || $urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 99);
      if (r < 55)      val = 8'($urandom_range(1, 4));
      else if (r < 75) val = 8'($urandom_range(5, 16));
      else if (r < 83) val = 8'h00;
      else if (r < 89) val = 8'(MAX_REGS);
      else if (r < 93) val = 8'($urandom_range(126, 255));   // clamp and bit 7 dropped
      else             val = 8'($urandom_range(17, 124));
      write_reg(CFG_EXP_COUNT, val);
    end
    settings_used++;
    calm = ($urandom_range(0, 4) == 0);
    // the last phase may have left a partial frame; the new length applies now
    if (frame_pos != 0) begin
      send_item(byte_item(8'($urandom_range(0, 255))));
      if (frame_pos != 0) send_item(timeout_item(8'($urandom_range(0, 255))));
    end
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_random_frame();
    // sometimes leave a frame open across the next register write
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) send_item(byte_item(8'($urandom_range(0, 255))));
    calm = 1'b0;
  endtask

  // Receiver stall: mostly free, short bursts, now and then a long one.
  always @(negedge clk) begin : stall_gen
    int r;
    if (!rst_n || calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // Every taken result is checked against the oldest awaited one.
  always @(posedge clk) begin : result_check
    mbrrc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_item.kind == KIND_DATA) words_seen++;
      else status_seen[out_item.status]++;
      if (awaited_reply_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d value=%h idx=%0d st=%0d exc=%h",
                             out_item.kind, out_item.word_value, out_item.word_index,
                             out_item.status, out_item.exception_code));
      end else begin
        want = awaited_reply_results.pop_front();
        if (out_item.kind !== want.kind || out_item.word_value !== want.word_value ||
            out_item.word_index !== want.word_index || out_item.status !== want.status ||
            out_item.exception_code !== want.exception_code)
          flag_error($sformatf({"result %0d: expected kind=%0d value=%h idx=%0d st=%0d ",
                                "exc=%h, got kind=%0d value=%h idx=%0d st=%0d exc=%h"},
                               results_seen, want.kind, want.word_value, want.word_index,
                               want.status, want.exception_code, out_item.kind,
                               out_item.word_value, out_item.word_index, out_item.status,
                               out_item.exception_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("watchdog: run did not finish within %0d cycles", LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : main
    logic [15:0] crc_snap;
    // Directed rows. Idle timeout first, then a good one-register reply under
    // the reset setting, then zero-length frames at address FF: exception,
    // clean, bad CRC and a timeout partway through the header.
    add_row(ROW_TIMEOUT, 8'hFF, 1'b1, stat_res(ST_TIMEOUT, 8'h00));
    add_row(ROW_BYTE, 8'h09);
    add_row(ROW_BYTE, FUNC_READ_HOLD);
    add_row(ROW_BYTE, 8'h02);
    add_row(ROW_BYTE, 8'h12);
    add_row(ROW_BYTE, 8'h34, 1'b1, word_res(16'h1234, 7'd0));
    add_row(ROW_CRC, 8'h00, 1'b1, stat_res(ST_OK, 8'h00));
    add_cfg(CFG_SLAVE_ADDR, 8'hFF);
    add_cfg(CFG_EXP_COUNT, 8'h00);
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, FUNC_READ_HOLD | FUNC_EXC_FLAG);
    add_row(ROW_BYTE, 8'h0B);
    add_row(ROW_CRC, 8'h00, 1'b1, stat_res(ST_EXCEPTION, 8'h0B));
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, FUNC_READ_HOLD);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_CRC, 8'h00, 1'b1, stat_res(ST_OK, 8'h00));
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, FUNC_READ_HOLD);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_CRC, 8'h80, 1'b1, stat_res(ST_CRC_BAD, 8'h00));
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, FUNC_READ_HOLD);
    add_row(ROW_TIMEOUT, 8'h00, 1'b1, stat_res(ST_TIMEOUT, 8'h00));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      case (script[i].op)
        ROW_CFG: begin
          settle();
          write_reg(script[i].reg_sel, script[i].val);
        end
        ROW_BYTE:    send_item(byte_item(script[i].val), script[i].typed, script[i].want);
        ROW_TIMEOUT: send_item(timeout_item(script[i].val), script[i].typed, script[i].want);
        ROW_CRC: begin
          // CRC of the frame so far, low byte first; val corrupts the low byte
          crc_snap = frame_crc;
          send_item(byte_item(crc_snap[7:0] ^ script[i].val));
          send_item(byte_item(crc_snap[15:8]), script[i].typed, script[i].want);
        end
        default: ;
      endcase
    end

    run_phase(1'b1);
    while (items_sent < ITEM_TARGET) run_phase(1'b0);
    settle();

    $display("covered %0d items under %0d register settings, %0d results (%0d data words)",
             items_sent, settings_used, results_seen, words_seen);
    $display("frame status: ok %0d timeout %0d crc %0d addr %0d exc %0d func %0d count %0d",
             status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_CRC_BAD],
             status_seen[ST_WRONG_ADDR], status_seen[ST_EXCEPTION], status_seen[ST_BAD_FUNC],
             status_seen[ST_COUNT_BAD]);
    if (mismatch_count == 0 && awaited_reply_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, awaited_reply_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
